// File: rtl/dependency_count_issue_scheduler_macros.svh
// assertion macros for the dependency count issue scheduler
`ifndef DEPENDENCY_COUNT_ISSUE_SCHEDULER_MACROS_SVH
`define DEPENDENCY_COUNT_ISSUE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while in reset
`define DCIS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcis assertion failed");

// next-cycle implication
`define DCIS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcis assertion failed");

`else

`define DCIS_ASSERT_IMPL(name, ante, cons)
`define DCIS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: rtl/dcis_pkg.sv
// types, constants and helpers shared by the dependency count issue scheduler
package dcis_pkg;

  localparam int NODES    = 1024;
  localparam int MAX_SUCC = 16;
  localparam int ID_W     = 16;
  localparam int IDX_W    = $clog2(NODES);
  localparam int TOT_W    = $clog2(MAX_SUCC + 1);
  localparam int PEND_W   = 11;
  localparam int SADDR_W  = $clog2(NODES * MAX_SUCC);

  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

  typedef enum logic [1:0] {
    OP_DECLARE = 2'd0,
    OP_EDGE    = 2'd1,
    OP_LAUNCH  = 2'd2,
    OP_DONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ISSUED = 3'd0,
    ST_NONE   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_UNDECL = 3'd4
  } status_t;

  typedef struct packed {
    op_t             operation;
    logic [ID_W-1:0] node_id;
    logic [ID_W-1:0] pred_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] issued_id;
    status_t         status;
    logic [ID_W-1:0] completed_count;
    logic            last;
  } out_item_t;

  // one row of the node table
  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic              issued;
    logic              declared;
    logic [TOT_W-1:0]  total;
  } node_ent_t;

  function automatic logic [SADDR_W-1:0] succ_addr(logic [IDX_W-1:0] idx,
                                                   logic [TOT_W-1:0] k);
    return SADDR_W'(idx * MAX_SUCC + k);
  endfunction

endpackage

// File: rtl/dependency_count_issue_scheduler.sv
// top level: dependency count issue scheduler over a node table and successor store
//
// Usage: raise start with in_item while busy is low; that edge is the transfer of
// one command (declare, add edge, launch, done). Results come out on out_item with
// out_valid high for exactly one cycle each; the last result of a command has
// out_item.last set. The receiver cannot stall, so out_item has no back-pressure.
// cfg_we writes cfg_wdata into id_base at any edge out of reset; write it only while idle.
// An id out of range is answered from idle; declare and launch read one node row
// and write it back as needed; add edge reads the predecessor and dependent rows
// and updates both (one row for a self edge); done walks up to 16 successors.
// The done walk is bound by the node table: each successor costs one read of
// the successor store and one read-modify-write of the node table.
// Every result is registered; an out-of-range result appears in the cycle after the accept.
// After reset the node table is swept to zero, one row per cycle over all 1024 rows,
// with busy high; the successor store is not cleared.
`include "dependency_count_issue_scheduler_macros.svh"

module dependency_count_issue_scheduler (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  dcis_pkg::in_item_t      in_item,
  output logic                    out_valid,
  output dcis_pkg::out_item_t     out_item,
  input  logic                    cfg_we,
  input  logic [dcis_pkg::ID_W-1:0] cfg_wdata
);
  import dcis_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RD1    = 8'b0000_0100,
    S_RD2    = 8'b0000_1000,
    S_EDGE_W = 8'b0001_0000,
    S_WALK_N = 8'b0010_0000,
    S_WALK_U = 8'b0100_0000,
    S_FLUSH  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [ID_W-1:0]     id_base_r;
  logic [ID_W-1:0]     done_cnt_r, done_cnt_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  op_t                 op_r, op_nxt;
  logic [IDX_W-1:0]    node_r, node_nxt;
  logic [IDX_W-1:0]    pred_r, pred_nxt;
  logic [IDX_W-1:0]    s_r, s_nxt;
  node_ent_t           pred_ent_r, pred_ent_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic [TOT_W-1:0]    k_r, k_nxt;
  out_item_t           hold_r, hold_nxt;
  out_item_t           out_r, out_nxt;

  logic                nm_we;
  logic [IDX_W-1:0]    nm_waddr, nm_raddr;
  node_ent_t           nm_wdata, nm_rdata;
  logic                sm_we;
  logic [SADDR_W-1:0]  sm_waddr, sm_raddr;
  logic [IDX_W-1:0]    sm_wdata, sm_rdata;

  logic [ID_W-1:0]     rel_node, rel_pred;
  logic                node_ok, pred_ok;
  node_ent_t           ent_w;
  logic                same;

  function automatic out_item_t make_res(logic [IDX_W-1:0] idx, status_t st, logic lst,
                                         logic [ID_W-1:0] base, logic [ID_W-1:0] cnt);
    out_item_t r;
    r.issued_id       = (st == ST_ISSUED) ? ID_W'(idx) + base : '0;
    r.status          = st;
    r.completed_count = cnt;
    r.last            = lst;
    return r;
  endfunction

  dcis_ram #(
    .WIDTH ($bits(node_ent_t)),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  dcis_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NODES * MAX_SUCC)
  ) u_succ_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign rel_node = in_item.node_id - id_base_r;
  assign rel_pred = in_item.pred_id - id_base_r;
  assign node_ok  = ({1'b0, rel_node} < (ID_W + 1)'(NODES));
  assign pred_ok  = ({1'b0, rel_pred} < (ID_W + 1)'(NODES));
  assign same     = (pred_r == node_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    done_cnt_nxt   = done_cnt_r;
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = 1'b0;
    op_nxt         = op_r;
    node_nxt       = node_r;
    pred_nxt       = pred_r;
    s_nxt          = s_r;
    pred_ent_nxt   = pred_ent_r;
    total_nxt      = total_r;
    k_nxt          = k_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    nm_we          = 1'b0;
    nm_waddr       = node_r;
    nm_wdata       = nm_rdata;
    nm_raddr       = node_r;
    sm_we          = 1'b0;
    sm_waddr       = succ_addr(pred_r, pred_ent_r.total);
    sm_wdata       = node_r;
    sm_raddr       = succ_addr(node_r, k_r);
    ent_w          = nm_rdata;

    case (state_r)
      S_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = clr_r;
        nm_wdata = '0;
        if (clr_r == IDX_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          if (!node_ok || (in_item.operation == OP_EDGE && !pred_ok)) begin
            out_valid_nxt = 1'b1;
            out_nxt = make_res('0, ST_RANGE, 1'b1, id_base_r, done_cnt_r);
          end else begin
            op_nxt    = in_item.operation;
            node_nxt  = rel_node[IDX_W-1:0];
            pred_nxt  = rel_pred[IDX_W-1:0];
            // an edge reads the predecessor first, then the dependent
            nm_raddr  = (in_item.operation == OP_EDGE) ? rel_pred[IDX_W-1:0]
                                                       : rel_node[IDX_W-1:0];
            state_nxt = S_RD1;
          end
        end
      end

      S_RD1: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_DECLARE: begin
            ent_w.declared = 1'b1;
            nm_we          = 1'b1;
            nm_wdata       = ent_w;
            out_valid_nxt  = 1'b1;
            out_nxt = make_res('0, ST_NONE, 1'b1, id_base_r, done_cnt_r);
          end
          OP_LAUNCH: begin
            out_valid_nxt = 1'b1;
            if (!nm_rdata.declared) begin
              out_nxt = make_res('0, ST_UNDECL, 1'b1, id_base_r, done_cnt_r);
            end else if (nm_rdata.pend == '0 && !nm_rdata.issued) begin
              ent_w.issued = 1'b1;
              nm_we        = 1'b1;
              nm_wdata     = ent_w;
              out_nxt = make_res(node_r, ST_ISSUED, 1'b1, id_base_r, done_cnt_r);
            end else begin
              out_nxt = make_res('0, ST_NONE, 1'b1, id_base_r, done_cnt_r);
            end
          end
          OP_EDGE: begin
            pred_ent_nxt = nm_rdata;
            nm_raddr     = node_r;
            state_nxt    = S_RD2;
          end
          OP_DONE: begin
            if (!nm_rdata.declared) begin
              out_valid_nxt = 1'b1;
              out_nxt = make_res('0, ST_UNDECL, 1'b1, id_base_r, done_cnt_r);
            end else begin
              done_cnt_nxt = done_cnt_r + ID_W'(1);
              total_nxt    = nm_rdata.total;
              k_nxt        = '0;
              sm_raddr     = succ_addr(node_r, '0);
              state_nxt    = (nm_rdata.total == '0) ? S_FLUSH : S_WALK_N;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_RD2: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (!nm_rdata.declared || !pred_ent_r.declared) begin
          out_nxt = make_res('0, ST_UNDECL, 1'b1, id_base_r, done_cnt_r);
        end else if (pred_ent_r.total >= TOT_W'(MAX_SUCC)) begin
          out_nxt = make_res('0, ST_FULL, 1'b1, id_base_r, done_cnt_r);
        end else begin
          sm_we = 1'b1;
          if (nm_rdata.pend != PEND_MAX) begin
            ent_w.pend = nm_rdata.pend + PEND_W'(1);
          end
          // self edge: both updates land in the one row
          if (same) begin
            ent_w.total = nm_rdata.total + TOT_W'(1);
          end
          nm_we    = 1'b1;
          nm_waddr = node_r;
          nm_wdata = ent_w;
          out_nxt  = make_res('0, ST_NONE, 1'b1, id_base_r, done_cnt_r);
          if (!same) begin
            state_nxt = S_EDGE_W;
          end
        end
      end

      S_EDGE_W: begin
        ent_w       = pred_ent_r;
        ent_w.total = pred_ent_r.total + TOT_W'(1);
        nm_we       = 1'b1;
        nm_waddr    = pred_r;
        nm_wdata    = ent_w;
        state_nxt   = S_IDLE;
      end

      S_WALK_N: begin
        s_nxt     = sm_rdata;
        nm_raddr  = sm_rdata;
        state_nxt = S_WALK_U;
      end

      S_WALK_U: begin
        if (nm_rdata.pend != '0) begin
          ent_w.pend = nm_rdata.pend - PEND_W'(1);
          nm_we      = 1'b1;
          nm_waddr   = s_r;
          if (nm_rdata.pend == PEND_W'(1) && !nm_rdata.issued) begin
            ent_w.issued = 1'b1;
            // keep one result back so the final one can carry last
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
            end
            hold_valid_nxt = 1'b1;
            hold_nxt = make_res(s_r, ST_ISSUED, 1'b0, id_base_r, done_cnt_r);
          end
          nm_wdata = ent_w;
        end
        if (k_r == total_r - TOT_W'(1)) begin
          state_nxt = S_FLUSH;
        end else begin
          k_nxt     = k_r + TOT_W'(1);
          sm_raddr  = succ_addr(node_r, k_r + TOT_W'(1));
          state_nxt = S_WALK_N;
        end
      end

      S_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (hold_valid_r) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
        end else begin
          out_nxt = make_res('0, ST_NONE, 1'b1, id_base_r, done_cnt_r);
        end
        hold_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      id_base_r    <= '0;
      done_cnt_r   <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      done_cnt_r   <= done_cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        id_base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    node_r     <= node_nxt;
    pred_r     <= pred_nxt;
    s_r        <= s_nxt;
    pred_ent_r <= pred_ent_nxt;
    total_r    <= total_nxt;
    k_r        <= k_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
  end

  `DCIS_ASSERT_IMPL(a_no_out_in_clear, state_r == S_CLEAR, !out_valid_r)
  `DCIS_ASSERT_IMPL(a_hold_only_in_walk, hold_valid_r, state_r == S_WALK_N || state_r == S_WALK_U || state_r == S_FLUSH)
  `DCIS_ASSERT_IMPL(a_walk_in_bounds, state_r == S_WALK_N || state_r == S_WALK_U, k_r < total_r)
  `DCIS_ASSERT_IMPL(a_non_issue_is_last, out_valid_r && out_r.status != ST_ISSUED, out_r.last)
  `DCIS_ASSERT_NEXT(a_flush_gives_last, state_r == S_FLUSH, out_valid_r && out_r.last)

endmodule

// File: rtl/dcis_ram.sv
// generic single write port ram with one registered read port
module dcis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
